FILE: hdl/gga_pkg.sv
// ----------------------------------------------------------------------------
// gga_pkg
// shared types, character codes and small constant tables of the gga parser
// ----------------------------------------------------------------------------
package gga_pkg;

	// ascii codes used by the parser
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_S      = 8'h53;
	localparam logic [7:0] CH_W      = 8'h57;

	// saturation limits
	localparam logic [39:0] COORD_CAP  = 40'd999999999999;
	localparam logic [39:0] LENGTH_CAP = 40'd99999999;
	localparam logic [39:0] UTC_CAP    = 40'd999999;
	localparam logic [39:0] SAT_CAP    = 40'd99;
	localparam logic [31:0] LAT_LIMIT  = 32'd900000000;
	localparam logic [31:0] LON_LIMIT  = 32'd1800000000;

	// one finished sentence, handed from front to back
	typedef struct packed {
		logic        valid;
		logic [19:0] utc;
		logic [39:0] lat_raw;
		logic [2:0]  lat_fd;
		logic [39:0] lon_raw;
		logic [2:0]  lon_fd;
		logic [6:0]  sat;
		logic [26:0] alt_raw;
		logic [1:0]  alt_fd;
		logic [26:0] hgt_raw;
		logic [1:0]  hgt_fd;
		logic [3:0]  sgn;
		logic [7:0]  checksum;
	} rec_t;

	// powers of ten up to 10^7
	function automatic logic [31:0] pow10(input logic [3:0] n);
		logic [31:0] r;
		unique case (n)
			4'd0: r = 32'd1;
			4'd1: r = 32'd10;
			4'd2: r = 32'd100;
			4'd3: r = 32'd1000;
			4'd4: r = 32'd10000;
			4'd5: r = 32'd100000;
			4'd6: r = 32'd1000000;
			4'd7: r = 32'd10000000;
			default: r = 32'd1;
		endcase
		return r;
	endfunction

	// expected header text "$GPGGA"
	function automatic logic [7:0] hdr_char(input logic [2:0] i);
		logic [7:0] c;
		unique case (i)
			3'd0: c = 8'h24;
			3'd1: c = 8'h47;
			3'd2: c = 8'h50;
			3'd3: c = 8'h47;
			3'd4: c = 8'h47;
			3'd5: c = 8'h41;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

FILE: hdl/gga_front.sv
// ----------------------------------------------------------------------------
// gga_front
// per-byte field splitter, checksum and digit accumulators of one sentence
// ----------------------------------------------------------------------------
module gga_front #(
	parameter int MIN_COORD_CHARS        = 6,
	parameter int MINUTE_FRACTION_DIGITS = 5,
	parameter int LENGTH_FRACTION_DIGITS = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [7:0]    in_byte,
	input  logic          in_last,
	output logic          in_ready,
	output logic          push,
	output gga_pkg::rec_t push_rec,
	input  logic          full
);

	localparam logic [1:0] PH_INT  = 2'd0;
	localparam logic [1:0] PH_FRAC = 2'd1;
	localparam logic [1:0] PH_STOP = 2'd2;

	localparam logic [2:0] FMAX_C = 3'(MINUTE_FRACTION_DIGITS);
	localparam logic [2:0] FMAX_L = 3'(LENGTH_FRACTION_DIGITS);

	typedef struct packed {
		logic [3:0]  idx;
		logic [4:0]  len;
		logic        hdr;
		logic        star;
		logic [7:0]  x;
		logic [19:0] utc;
		logic [39:0] lat;
		logic [39:0] lon;
		logic [2:0]  fdc;
		logic [1:0]  ph;
		logic        qnz;
		logic [6:0]  sat;
		logic [26:0] alt;
		logic [26:0] hgt;
		logic [3:0]  sgn;
		logic [1:0]  cok;
		logic [2:0]  latfd;
		logic [2:0]  lonfd;
		logic [1:0]  altfd;
		logic [1:0]  hgtfd;
	} fs_t;

	typedef struct packed {
		logic [39:0] acc;
		logic [1:0]  ph;
		logic [2:0]  fdc;
	} num_t;

	localparam fs_t FS_RESET = '{hdr: 1'b1, default: '0};

	fs_t st_q;
	fs_t ns;
	fs_t cs;
	num_t nr;
	logic accept;

	// one byte of a decimal number
	function automatic num_t num_byte(input logic [39:0] acc, input logic [2:0] fmax,
		input logic [39:0] cap, input logic [7:0] b, input logic [1:0] ph,
		input logic [2:0] fdc);
		num_t r;
		logic [43:0] t;
		r.acc = acc;
		r.ph  = ph;
		r.fdc = fdc;
		t = {acc, 3'b000} + {1'b0, acc, 1'b0} + {36'd0, b - gga_pkg::CH_0};
		if (ph != PH_STOP) begin
			if (b >= gga_pkg::CH_0 && b <= gga_pkg::CH_9) begin
				if (ph == PH_INT || fdc < fmax) begin
					r.acc = (t > {4'd0, cap}) ? cap : t[39:0];
					if (ph == PH_FRAC) begin
						r.fdc = fdc + 3'd1;
					end
				end
			end else if (b == gga_pkg::CH_DOT && ph == PH_INT && fmax != 3'd0) begin
				r.ph = PH_FRAC;
			end else begin
				r.ph = PH_STOP;
			end
		end
		return r;
	endfunction

	// effects of closing the current field
	function automatic fs_t close_f(input fs_t s);
		fs_t r;
		r = s;
		unique case (s.idx)
			4'd0: if (s.len != 5'd6) r.hdr = 1'b0;
			4'd2: begin
				if (s.len >= 5'(MIN_COORD_CHARS)) r.cok[0] = 1'b1;
				r.latfd = s.fdc;
			end
			4'd3: if (s.len != 5'd1) r.sgn[0] = 1'b0;
			4'd4: begin
				if (s.len >= 5'(MIN_COORD_CHARS)) r.cok[1] = 1'b1;
				r.lonfd = s.fdc;
			end
			4'd5: if (s.len != 5'd1) r.sgn[1] = 1'b0;
			4'd9: r.altfd = s.fdc[1:0];
			4'd11: r.hgtfd = s.fdc[1:0];
			default: r = s;
		endcase
		return r;
	endfunction

	assign accept   = in_valid && in_ready;
	assign in_ready = !full;

	// next state for the byte on the input
	always_comb begin
		ns = st_q;
		nr = '0;
		if (!ns.star) begin
			if (in_byte == gga_pkg::CH_STAR) ns.star = 1'b1;
			else if (in_byte != gga_pkg::CH_DOLLAR) ns.x = ns.x ^ in_byte;
		end
		if (in_byte == gga_pkg::CH_COMMA) begin
			ns = close_f(ns);
			if (ns.idx != 4'd15) ns.idx = ns.idx + 4'd1;
			ns.len = '0;
			ns.fdc = '0;
			ns.ph  = PH_INT;
		end else begin
			unique case (st_q.idx)
				4'd0: begin
					if (st_q.len >= 5'd6 || in_byte != gga_pkg::hdr_char(st_q.len[2:0]))
						ns.hdr = 1'b0;
				end
				4'd1: begin
					nr = num_byte({20'd0, st_q.utc}, 3'd0, gga_pkg::UTC_CAP, in_byte,
						st_q.ph, st_q.fdc);
					ns.utc = nr.acc[19:0];
					ns.ph  = nr.ph;
					ns.fdc = nr.fdc;
				end
				4'd2: begin
					nr = num_byte(st_q.lat, FMAX_C, gga_pkg::COORD_CAP, in_byte,
						st_q.ph, st_q.fdc);
					ns.lat = nr.acc;
					ns.ph  = nr.ph;
					ns.fdc = nr.fdc;
				end
				4'd3: if (st_q.len == 5'd0 && in_byte == gga_pkg::CH_S) ns.sgn[0] = 1'b1;
				4'd4: begin
					nr = num_byte(st_q.lon, FMAX_C, gga_pkg::COORD_CAP, in_byte,
						st_q.ph, st_q.fdc);
					ns.lon = nr.acc;
					ns.ph  = nr.ph;
					ns.fdc = nr.fdc;
				end
				4'd5: if (st_q.len == 5'd0 && in_byte == gga_pkg::CH_W) ns.sgn[1] = 1'b1;
				4'd6: begin
					if (st_q.ph == PH_INT) begin
						if (in_byte >= gga_pkg::CH_0 && in_byte <= gga_pkg::CH_9) begin
							if (in_byte != gga_pkg::CH_0) ns.qnz = 1'b1;
						end else begin
							ns.ph = PH_STOP;
						end
					end
				end
				4'd7: begin
					nr = num_byte({33'd0, st_q.sat}, 3'd0, gga_pkg::SAT_CAP, in_byte,
						st_q.ph, st_q.fdc);
					ns.sat = nr.acc[6:0];
					ns.ph  = nr.ph;
					ns.fdc = nr.fdc;
				end
				4'd9: begin
					if (st_q.len == 5'd0 &&
						(in_byte == gga_pkg::CH_MINUS || in_byte == gga_pkg::CH_PLUS)) begin
						if (in_byte == gga_pkg::CH_MINUS) ns.sgn[2] = 1'b1;
					end else begin
						nr = num_byte({13'd0, st_q.alt}, FMAX_L, gga_pkg::LENGTH_CAP,
							in_byte, st_q.ph, st_q.fdc);
						ns.alt = nr.acc[26:0];
						ns.ph  = nr.ph;
						ns.fdc = nr.fdc;
					end
				end
				4'd11: begin
					if (st_q.len == 5'd0 &&
						(in_byte == gga_pkg::CH_MINUS || in_byte == gga_pkg::CH_PLUS)) begin
						if (in_byte == gga_pkg::CH_MINUS) ns.sgn[3] = 1'b1;
					end else begin
						nr = num_byte({13'd0, st_q.hgt}, FMAX_L, gga_pkg::LENGTH_CAP,
							in_byte, st_q.ph, st_q.fdc);
						ns.hgt = nr.acc[26:0];
						ns.ph  = nr.ph;
						ns.fdc = nr.fdc;
					end
				end
				default: ns.idx = st_q.idx;
			endcase
			if (ns.len != 5'd31) ns.len = ns.len + 5'd1;
		end
		cs = close_f(ns);
	end

	// sentence record on the last byte
	always_comb begin
		push_rec.valid    = cs.hdr && cs.idx >= 4'd11 && cs.qnz && cs.sat != 7'd0 &&
			cs.cok == 2'b11;
		push_rec.utc      = cs.utc;
		push_rec.lat_raw  = cs.lat;
		push_rec.lat_fd   = cs.latfd;
		push_rec.lon_raw  = cs.lon;
		push_rec.lon_fd   = cs.lonfd;
		push_rec.sat      = cs.sat;
		push_rec.alt_raw  = cs.alt;
		push_rec.alt_fd   = cs.altfd;
		push_rec.hgt_raw  = cs.hgt;
		push_rec.hgt_fd   = cs.hgtfd;
		push_rec.sgn      = cs.sgn;
		push_rec.checksum = cs.x;
	end

	assign push = accept && in_last;

	// parser state, cleared after every sentence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= FS_RESET;
		end else if (accept) begin
			if (in_last) st_q <= FS_RESET;
			else st_q <= ns;
		end
	end

endmodule

FILE: hdl/gga_queue.sv
// ----------------------------------------------------------------------------
// gga_queue
// two-entry queue of finished sentence records between front and back
// ----------------------------------------------------------------------------
module gga_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  gga_pkg::rec_t din,
	output logic          full,
	input  logic          pop,
	output gga_pkg::rec_t dout,
	output logic          empty
);

	gga_pkg::rec_t mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign dout  = mem_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= din;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

FILE: hdl/gga_back.sv
// ----------------------------------------------------------------------------
// gga_back
// coordinate conversion sequencer, length scaling and output register
// ----------------------------------------------------------------------------
module gga_back #(
	parameter int MINUTE_FRACTION_DIGITS = 5,
	parameter int LENGTH_FRACTION_DIGITS = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          empty,
	input  gga_pkg::rec_t head,
	output logic          pop,
	output logic          m_valid,
	input  logic          m_ready,
	output logic [159:0]  m_data,
	output logic          m_flag
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCALE = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_MULT  = 3'd4;
	localparam logic [2:0] ST_DIV60 = 3'd5;
	localparam logic [2:0] ST_SUM   = 3'd6;
	localparam logic [2:0] ST_FIN   = 3'd7;

	localparam logic [2:0]  M_DIG   = 3'(MINUTE_FRACTION_DIGITS);
	localparam logic [1:0]  L_DIG   = 2'(LENGTH_FRACTION_DIGITS);
	localparam logic [63:0] UNIT    = 64'd100 * 64'(gga_pkg::pow10(4'(MINUTE_FRACTION_DIGITS)));
	localparam logic [59:0] DEG_CAP = 60'(64'd1000 * UNIT);
	localparam logic [39:0] UNIT40  = 40'(UNIT);
	localparam logic [39:0] UNIT40_X10  = 40'(64'd10 * UNIT);
	localparam logic [39:0] UNIT40_X100 = 40'(64'd100 * UNIT);
	localparam logic [19:0] MSCALE  = 20'(gga_pkg::pow10(4'(7 - MINUTE_FRACTION_DIGITS)));
	// ceil(2^32 / 15), exact quotient for dividends below 2^28
	localparam logic [28:0] RECIP15 = 29'd286331154;

	logic [2:0]    state_q;
	gga_pkg::rec_t rec_q;
	logic          sel_q;
	logic [59:0]   acc_q;
	logic [2:0]    cnt_q;
	logic [39:0]   rem_q;
	logic [9:0]    quo_q;
	logic [1:0]    dig_q;
	logic [29:0]   rem60_q;
	logic [23:0]   q60_q;
	logic [31:0]   lat_mag_q;
	logic [31:0]   lon_mag_q;
	logic          m_valid_q;
	logic [159:0]  m_data_q;
	logic          m_flag_q;

	logic [39:0] dw;
	logic [39:0] dsub;
	logic [3:0]  dnum;
	logic [56:0] prod60;
	logic [46:0] mprod;
	logic [33:0] vsum;
	logic [31:0] vsat;
	logic [31:0] limit;
	logic        out_free;
	logic [36:0] alt_p;
	logic [36:0] hgt_p;
	logic [26:0] alt_m;
	logic [26:0] hgt_m;
	logic [30:0] lat_o;
	logic [31:0] lon_o;
	logic [27:0] alt_o;
	logic [27:0] hgt_o;

	assign out_free = !m_valid_q || m_ready;
	assign pop      = state_q == ST_IDLE && !empty;
	assign m_valid  = m_valid_q;
	assign m_data   = m_data_q;
	assign m_flag   = m_flag_q;

	// datapath of one conversion step
	always_comb begin
		// weight of the decimal degree digit being found
		unique case (dig_q)
			2'd2: dw = UNIT40_X100;
			2'd1: dw = UNIT40_X10;
			default: dw = UNIT40;
		endcase
		// largest multiple of the weight that fits
		dnum = 4'd0;
		dsub = '0;
		for (int k = 1; k <= 9; k++) begin
			if (rem_q >= 40'(k) * dw) begin
				dnum = 4'(k);
				dsub = 40'(k) * dw;
			end
		end
		// divide by 60 as a quarter divided by 15
		prod60  = 57'(rem60_q[29:2]) * 57'(RECIP15);
		mprod   = 47'(rem_q[26:0]) * 47'(MSCALE);
		vsum    = 34'(quo_q) * 34'd10000000 + 34'(q60_q);
		limit   = sel_q ? gga_pkg::LON_LIMIT : gga_pkg::LAT_LIMIT;
		vsat    = (vsum > 34'(limit)) ? limit : vsum[31:0];
	end

	// final scaling, signs and field packing
	always_comb begin
		alt_p = 37'(rec_q.alt_raw) * 37'(gga_pkg::pow10(4'(L_DIG - rec_q.alt_fd)));
		hgt_p = 37'(rec_q.hgt_raw) * 37'(gga_pkg::pow10(4'(L_DIG - rec_q.hgt_fd)));
		alt_m = (alt_p > 37'(gga_pkg::LENGTH_CAP)) ? 27'(gga_pkg::LENGTH_CAP) : alt_p[26:0];
		hgt_m = (hgt_p > 37'(gga_pkg::LENGTH_CAP)) ? 27'(gga_pkg::LENGTH_CAP) : hgt_p[26:0];
		lat_o = rec_q.sgn[0] ? 31'(~lat_mag_q + 32'd1) : lat_mag_q[30:0];
		lon_o = rec_q.sgn[1] ? (~lon_mag_q + 32'd1) : lon_mag_q;
		alt_o = rec_q.sgn[2] ? (~{1'b0, alt_m} + 28'd1) : {1'b0, alt_m};
		hgt_o = rec_q.sgn[3] ? (~{1'b0, hgt_m} + 28'd1) : {1'b0, hgt_m};
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			if (m_valid_q && m_ready && state_q != ST_FIN) m_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						rec_q <= head;
						sel_q <= 1'b0;
						acc_q <= 60'(head.lat_raw);
						cnt_q <= M_DIG - head.lat_fd;
						state_q <= head.valid ? ST_SCALE : ST_FIN;
					end
				end
				ST_SCALE: begin
					if (cnt_q != 3'd0) begin
						acc_q <= {acc_q[56:0], 3'b000} + {acc_q[58:0], 1'b0};
						cnt_q <= cnt_q - 3'd1;
					end else begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (acc_q >= DEG_CAP) begin
						if (sel_q) begin
							lon_mag_q <= gga_pkg::LON_LIMIT;
							state_q   <= ST_FIN;
						end else begin
							lat_mag_q <= gga_pkg::LAT_LIMIT;
							sel_q     <= 1'b1;
							acc_q     <= 60'(rec_q.lon_raw);
							cnt_q     <= M_DIG - rec_q.lon_fd;
							state_q   <= ST_SCALE;
						end
					end else begin
						rem_q   <= acc_q[39:0];
						quo_q   <= '0;
						dig_q   <= 2'd2;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= rem_q - dsub;
					quo_q <= 10'(({quo_q, 3'b000} + {1'b0, quo_q, 1'b0}) + 13'(dnum));
					if (dig_q == 2'd0) state_q <= ST_MULT;
					else dig_q <= dig_q - 2'd1;
				end
				ST_MULT: begin
					rem60_q <= mprod[29:0];
					state_q <= ST_DIV60;
				end
				ST_DIV60: begin
					q60_q   <= prod60[55:32];
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					if (sel_q) begin
						lon_mag_q <= vsat;
						state_q   <= ST_FIN;
					end else begin
						lat_mag_q <= vsat;
						sel_q     <= 1'b1;
						acc_q     <= 60'(rec_q.lon_raw);
						cnt_q     <= M_DIG - rec_q.lon_fd;
						state_q   <= ST_SCALE;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						m_flag_q  <= rec_q.valid;
						if (rec_q.valid) begin
							m_data_q <= {6'd0, rec_q.checksum, hgt_o, alt_o, rec_q.sat,
								lon_o, lat_o, rec_q.utc};
						end else begin
							m_data_q <= {6'd0, rec_q.checksum, 146'd0};
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: hdl/gga_sentence_parser_core.sv
// ----------------------------------------------------------------------------
// gga_sentence_parser_core
// gga sentence parser: byte stream in, one position-fix word per sentence out
// ----------------------------------------------------------------------------
// Sentence bytes are taken at one byte per cycle while s_tready is high; s_tlast
// marks the last byte of a sentence and the result word for it appears on the
// master side later. Byte parsing, the checksum and digit accumulation happen in
// the cycle a byte is accepted. Finished sentences wait in a two-entry queue for
// the back end, which converts latitude and longitude one after the other: the
// degrees come from a decimal compare and subtract for the hundreds, tens and
// units digits, the minutes from a reciprocal multiply by 1/60. A valid sentence
// first scales each coordinate by ten for every missing minute fraction digit;
// a coordinate of 1000 degrees or more skips the division and is limited.
// An invalid sentence goes straight to the output register. s_tready drops only
// while two finished sentences are queued, so normal sentences of a few dozen
// bytes flow without stalls as long as m_tready is not held low. The result
// register lets the next sentence convert while a word waits on m_tready.
module gga_sentence_parser_core #(
	parameter int MIN_COORD_CHARS        = 6,
	parameter int MINUTE_FRACTION_DIGITS = 5,
	parameter int LENGTH_FRACTION_DIGITS = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // data_byte[7:0]
	input  logic         s_tlast,   // end_of_sentence
	output logic         m_tvalid,
	input  logic         m_tready,
	// utc_time[19:0], latitude[50:20], longitude[82:51], satellites[89:83],
	// altitude[117:90], geoid_height[145:118], checksum[153:146], zero pad
	output logic [159:0] m_tdata,
	output logic         m_tuser    // sentence_valid
);

	logic          push;
	logic          pop;
	logic          full;
	logic          empty;
	gga_pkg::rec_t push_rec;
	gga_pkg::rec_t head;

	// byte parser
	gga_front #(
		.MIN_COORD_CHARS       (MIN_COORD_CHARS),
		.MINUTE_FRACTION_DIGITS(MINUTE_FRACTION_DIGITS),
		.LENGTH_FRACTION_DIGITS(LENGTH_FRACTION_DIGITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_byte (s_tdata),
		.in_last (s_tlast),
		.in_ready(s_tready),
		.push    (push),
		.push_rec(push_rec),
		.full    (full)
	);

	// record queue
	gga_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (push_rec),
		.full  (full),
		.pop   (pop),
		.dout  (head),
		.empty (empty)
	);

	// conversion and output
	gga_back #(
		.MINUTE_FRACTION_DIGITS(MINUTE_FRACTION_DIGITS),
		.LENGTH_FRACTION_DIGITS(LENGTH_FRACTION_DIGITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.m_valid(m_tvalid),
		.m_ready(m_tready),
		.m_data (m_tdata),
		.m_flag (m_tuser)
	);

endmodule

FILE: hdl/gga_checker.sv
// ----------------------------------------------------------------------------
// gga_checker
// port-level checks of the gga parser output, bound to the top level
// ----------------------------------------------------------------------------
module gga_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [7:0]   s_tdata,
	input logic         s_tlast,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [159:0] m_tdata,
	input logic         m_tuser
);

	// stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// invalid sentence carries only the checksum
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[145:0] == 146'd0 && m_tdata[159:154] == 6'd0)
		else $error("invalid sentence with nonzero fields");

	// valid sentence has satellites in range
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[89:83] != 7'd0 && m_tdata[89:83] <= 7'd99)
		else $error("satellite count out of range");

	// utc saturates
	a_utc: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[19:0] <= 20'd999999)
		else $error("utc out of range");

	// input side is known
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown(s_tready) && (!s_tvalid || !$isunknown({s_tdata, s_tlast})))
		else $error("unknown value on input side");

endmodule

bind gga_sentence_parser_core gga_checker u_gga_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.s_tlast (s_tlast),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

FILE: bench/gga_fix_checker.sv
// ----------------------------------------------------------------------------
// gga_fix_checker
// watches both streams of the gga parser, predicts every fix word from the
// accepted sentence bytes and compares it field by field with the output
// ----------------------------------------------------------------------------
module gga_fix_checker #(
	parameter int MIN_COORD_CHARS        = 6,
	parameter int MINUTE_FRACTION_DIGITS = 5,
	parameter int LENGTH_FRACTION_DIGITS = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [7:0]   s_tdata,
	input  logic         s_tlast,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [159:0] m_tdata,
	input  logic         m_tuser,
	output int           error_count,
	output int           fixes_waiting
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic        valid;
		logic [19:0] utc;
		logic [30:0] lat;
		logic [31:0] lon;
		logic [6:0]  sat;
		logic [27:0] alt;
		logic [27:0] hgt;
		logic [7:0]  cks;
	} fix_t;

	localparam longint unsigned CRD_CAP = 64'd999999999999;
	localparam longint unsigned LEN_CAP = 64'd99999999;

	fix_t fix_q[$];
	int   errs = 0;

	// parser state of the predictor
	int unsigned     fld_idx, fld_len, frac_cnt, num_phase, sgn, crd_ok;
	bit              hdr_ok, star, qual_nz;
	logic [7:0]      xacc;
	longint unsigned utc_a, lat_a, lon_a, sat_a, alt_a, hgt_a;

	function automatic longint unsigned p10(int unsigned n);
		longint unsigned r;
		r = 1;
		repeat (n) r = r * 10;
		return r;
	endfunction

	function automatic logic [7:0] hdr_at(int unsigned i);
		logic [7:0] t[6];
		t = '{8'h24, 8'h47, 8'h50, 8'h47, 8'h47, 8'h41};
		return t[i];
	endfunction

	task automatic clear_state();
		fld_idx = 0; fld_len = 0; frac_cnt = 0; num_phase = 0; sgn = 0; crd_ok = 0;
		hdr_ok = 1; star = 0; qual_nz = 0; xacc = 0;
		utc_a = 0; lat_a = 0; lon_a = 0; sat_a = 0; alt_a = 0; hgt_a = 0;
	endtask

	// one character of a decimal number, fmax 0 means integer only
	function automatic longint unsigned num_char(longint unsigned acc, int unsigned fmax,
			longint unsigned cap, logic [7:0] b);
		longint unsigned a;
		a = acc;
		if (num_phase == 2) return a;
		if (b >= gga_pkg::CH_0 && b <= gga_pkg::CH_9) begin
			if (num_phase == 0) begin
				a = a * 10 + (b - gga_pkg::CH_0);
			end else if (frac_cnt < fmax) begin
				a = a * 10 + (b - gga_pkg::CH_0);
				frac_cnt++;
			end
			if (a > cap) a = cap;
		end else if (b == gga_pkg::CH_DOT && num_phase == 0 && fmax > 0) begin
			num_phase = 1;
		end else begin
			num_phase = 2;
		end
		return a;
	endfunction

	task automatic field_char(logic [7:0] b);
		case (fld_idx)
			0: if (fld_len >= 6 || b != hdr_at(fld_len)) hdr_ok = 0;
			1: utc_a = num_char(utc_a, 0, 999999, b);
			2: lat_a = num_char(lat_a, MINUTE_FRACTION_DIGITS, CRD_CAP, b);
			3: if (fld_len == 0 && b == gga_pkg::CH_S) sgn |= 1;
			4: lon_a = num_char(lon_a, MINUTE_FRACTION_DIGITS, CRD_CAP, b);
			5: if (fld_len == 0 && b == gga_pkg::CH_W) sgn |= 2;
			6: if (num_phase == 0) begin
				if (b >= gga_pkg::CH_0 && b <= gga_pkg::CH_9) begin
					if (b != gga_pkg::CH_0) qual_nz = 1;
				end else num_phase = 2;
			end
			7: sat_a = num_char(sat_a, 0, 99, b);
			9: if (fld_len == 0 && (b == gga_pkg::CH_MINUS || b == gga_pkg::CH_PLUS)) begin
				if (b == gga_pkg::CH_MINUS) sgn |= 4;
			end else alt_a = num_char(alt_a, LENGTH_FRACTION_DIGITS, LEN_CAP, b);
			11: if (fld_len == 0 && (b == gga_pkg::CH_MINUS || b == gga_pkg::CH_PLUS)) begin
				if (b == gga_pkg::CH_MINUS) sgn |= 8;
			end else hgt_a = num_char(hgt_a, LENGTH_FRACTION_DIGITS, LEN_CAP, b);
			default: ;
		endcase
	endtask

	task automatic field_end();
		case (fld_idx)
			0: if (fld_len != 6) hdr_ok = 0;
			2: begin
				if (fld_len >= MIN_COORD_CHARS) crd_ok |= 1;
				lat_a = lat_a * p10(MINUTE_FRACTION_DIGITS - frac_cnt);
			end
			3: if (fld_len != 1) sgn &= ~1;
			4: begin
				if (fld_len >= MIN_COORD_CHARS) crd_ok |= 2;
				lon_a = lon_a * p10(MINUTE_FRACTION_DIGITS - frac_cnt);
			end
			5: if (fld_len != 1) sgn &= ~2;
			9: begin
				alt_a = alt_a * p10(LENGTH_FRACTION_DIGITS - frac_cnt);
				if (alt_a > LEN_CAP) alt_a = LEN_CAP;
			end
			11: begin
				hgt_a = hgt_a * p10(LENGTH_FRACTION_DIGITS - frac_cnt);
				if (hgt_a > LEN_CAP) hgt_a = LEN_CAP;
			end
			default: ;
		endcase
	endtask

	// degrees and minutes to 1e-7 degrees, truncated and limited
	function automatic longint unsigned to_deg7(longint unsigned acc, longint unsigned lim);
		longint unsigned unit, deg, ms, v;
		unit = 100 * p10(MINUTE_FRACTION_DIGITS);
		deg = acc / unit;
		ms = acc % unit;
		if (deg > 999) return lim;
		v = deg * 10000000 + (ms * p10(7 - MINUTE_FRACTION_DIGITS)) / 60;
		return (v > lim) ? lim : v;
	endfunction

	task automatic take_byte(logic [7:0] b, logic last);
		fix_t f;
		longint unsigned m;
		if (!star) begin
			if (b == gga_pkg::CH_STAR) star = 1;
			else if (b != gga_pkg::CH_DOLLAR) xacc ^= b;
		end
		if (b == gga_pkg::CH_COMMA) begin
			field_end();
			if (fld_idx < 15) fld_idx++;
			fld_len = 0; frac_cnt = 0; num_phase = 0;
		end else begin
			field_char(b);
			if (fld_len < 31) fld_len++;
		end
		if (last) begin
			field_end();
			f = '0;
			f.valid = hdr_ok && fld_idx >= 11 && qual_nz && sat_a != 0 && crd_ok == 3;
			if (f.valid) begin
				f.utc = utc_a[19:0];
				m = to_deg7(lat_a, gga_pkg::LAT_LIMIT);
				f.lat = sgn[0] ? -m[30:0] : m[30:0];
				m = to_deg7(lon_a, gga_pkg::LON_LIMIT);
				f.lon = sgn[1] ? -m[31:0] : m[31:0];
				f.sat = sat_a[6:0];
				f.alt = sgn[2] ? -alt_a[27:0] : alt_a[27:0];
				f.hgt = sgn[3] ? -hgt_a[27:0] : hgt_a[27:0];
			end
			f.cks = xacc;
			fix_q.insert(fix_q.size(), f);
			clear_state();
		end
	endtask

	task automatic cmp(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$display("%0t mismatch %s expected %0h actual %0h", $time, name, want, got);
			errs++;
		end
	endtask

	assign error_count   = errs;
	assign fixes_waiting = fix_q.size();

	// sample both handshakes at the rising edge
	always @(posedge clk) begin
		fix_t want;
		if (!arst_n) begin
			clear_state();
		end else begin
			if (s_tvalid && s_tready) take_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				if (fix_q.size() == 0) begin
					$display("%0t unexpected fix word %0h", $time, m_tdata);
					errs++;
				end else begin
					want = fix_q.pop_front();
					cmp("sentence_valid", want.valid, m_tuser);
					cmp("utc_time", want.utc, m_tdata[19:0]);
					cmp("latitude", want.lat, m_tdata[50:20]);
					cmp("longitude", want.lon, m_tdata[82:51]);
					cmp("satellites", want.sat, m_tdata[89:83]);
					cmp("altitude", want.alt, m_tdata[117:90]);
					cmp("geoid_height", want.hgt, m_tdata[145:118]);
					cmp("checksum", want.cks, m_tdata[153:146]);
				end
			end
		end
	end

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// sentence stimulus for the gga parser: directed sentences, then random
// well-formed, broken and noise sentences with idles and long back-pressure
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [7:0]   s_tdata = 0;
	logic         s_tlast = 0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [159:0] m_tdata;
	logic         m_tuser;
	int           error_count, fixes_waiting;

	bit           idles_on = 1;
	bit           hold_req = 0;
	int           bytes_sent = 0;
	logic [7:0]   line_q[$];

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	gga_sentence_parser_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	gga_fix_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.error_count(error_count), .fixes_waiting(fixes_waiting)
	);

	// receiver: random idles, or one long hold-off each time it is asked
	initial begin
		int hold_cnt;
		bit hold_used;
		hold_cnt = 0;
		hold_used = 0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_used) begin
				hold_cnt = 600;
				hold_used = 1;
			end
			if (!hold_req) hold_used = 0;
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_tready <= 0;
			end else begin
				m_tready <= !(idles_on && $urandom_range(99) < 6);
			end
		end
	end

	task automatic put_str(string s);
		for (int i = 0; i < s.len(); i++) line_q.insert(line_q.size(), s[i]);
	endtask

	task automatic put_digits(int n);
		repeat (n) line_q.insert(line_q.size(), 8'(8'h30 + $urandom_range(9)));
	endtask

	// send the line queue, last byte marked
	task automatic send_line();
		int n;
		n = line_q.size();
		for (int i = 0; i < n; i++) begin
			while (idles_on && $urandom_range(99) < 6) begin
				s_tvalid <= 0;
				@(negedge clk);
			end
			s_tvalid <= 1;
			s_tdata <= line_q[i];
			s_tlast <= (i == n - 1);
			do @(posedge clk); while (!s_tready);
			@(negedge clk);
			bytes_sent++;
		end
		s_tvalid <= 0;
		line_q.delete();
	endtask

	task automatic put_coord(int deg_digits);
		put_digits($urandom_range(deg_digits + 2, deg_digits - 1));
		if ($urandom_range(9) > 0) begin
			put_str(".");
			put_digits($urandom_range(7));
		end
	endtask

	task automatic put_length();
		case ($urandom_range(3))
			0: put_str("-");
			1: put_str("+");
			default: ;
		endcase
		put_digits($urandom_range(9));
		if ($urandom_range(3) > 0) begin
			put_str(".");
			put_digits($urandom_range(4));
		end
	endtask

	// a plausible fix sentence with random content
	task automatic build_sentence();
		string ns[5], ew[5];
		ns = '{"N", "S", "", "SS", "x"};
		ew = '{"E", "W", "", "WW", "w"};
		put_str($urandom_range(19) ? "$GPGGA," : "$GPGGX,");
		put_digits($urandom_range(8));
		if ($urandom_range(1)) put_str(".00");
		put_str(",");
		put_coord(4);
		put_str({",", ns[$urandom_range(4)], ","});
		put_coord(5);
		put_str({",", ew[$urandom_range(4)], ","});
		put_digits($urandom_range(9) ? 1 : 0);
		put_str(",");
		put_digits($urandom_range(3));
		put_str(",1.2,");
		put_length();
		put_str(",M,");
		put_length();
		put_str(",M,,");
		if ($urandom_range(7)) begin
			put_str("*");
			put_digits(2);
		end
	endtask

	task automatic random_line();
		int kind, n, pos;
		kind = $urandom_range(99);
		if (kind < 75) begin
			build_sentence();
		end else if (kind < 85) begin
			// broken: cut short
			build_sentence();
			n = $urandom_range(line_q.size() - 1, 1);
			while (line_q.size() > n) void'(line_q.pop_back());
		end else if (kind < 93) begin
			// broken: one byte replaced
			build_sentence();
			pos = $urandom_range(line_q.size() - 1);
			line_q[pos] = 8'($urandom_range(255));
		end else begin
			repeat ($urandom_range(40, 1)) line_q.insert(line_q.size(), 8'($urandom_range(255)));
		end
	endtask

	initial begin
		int lines;
		repeat (10) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// directed sentences: extremes, signs, saturation, odd endings
		put_str("$GPGGA,999999,9059.99999,S,17959.99999,W,9,99,1,-999999.99,M,-999999.99,M,,*00");
		send_line();
		put_str("$GPGGA,0,000000,N,000000,E,1,1,0,0,M,0,M,,*FF");
		send_line();
		put_str("$GPGGA,99999999,99999999.999999,S,99999999.999999,W,1,12345,,99999999999,M,+9.999,M,");
		send_line();
		put_str("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47");
		send_line();
		put_str("$GPGGA,1,4899.9,N,01199.99,E,1,08,0.9,5,M,-46,M,,,,,,,,,,,,,,,,*$*47");
		send_line();
		put_str("$GPGGA,1,48,N,011,E,0,00,,,,,,");
		send_line();
		put_str(",");
		send_line();

		// random sentences, idles off for a stretch in the middle
		lines = 0;
		while (bytes_sent < 1950 || lines < 40) begin
			idles_on = !(lines >= 14 && lines < 24);
			if (lines == 6) hold_req = 1;
			if (lines == 12) hold_req = 0;
			if (lines == 28) begin
				wait (fixes_waiting == 0);
				repeat (100) @(negedge clk);
			end
			random_line();
			send_line();
			lines++;
		end

		wait (fixes_waiting == 0);
		repeat (200) @(negedge clk);
		if (error_count == 0 && fixes_waiting == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

	initial begin
		#10ms;
		$display("tb_top: errors");
		$finish;
	end

endmodule
